>>> rtl/hva_pkg.sv
package hva_pkg;

   // fixed field widths
   localparam int VALUE_BITS = 24;
   localparam int COUNT_BITS = 16;
   localparam int RES_BITS   = 23;
   localparam int FIRST_BITS = 24;
   localparam int INDEX_BITS = 6;

   // configuration port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // register indexes, paddr[3:2]
   localparam logic [1:0] REG_THETA_RES   = 2'd0;
   localparam logic [1:0] REG_R_RES       = 2'd1;
   localparam logic [1:0] REG_THETA_FIRST = 2'd2;
   localparam logic [1:0] REG_R_FIRST     = 2'd3;

   localparam logic [RES_BITS-1:0]   RES_RESET   = RES_BITS'(4096);
   localparam logic [FIRST_BITS-1:0] FIRST_RESET = FIRST_BITS'(-32);

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] theta_value;
      logic signed [VALUE_BITS-1:0] r_value;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] bin_count;
      logic                  out_of_range;
      logic [COUNT_BITS-1:0] best_count;
      logic [INDEX_BITS-1:0] best_theta_index;
      logic [INDEX_BITS-1:0] best_r_index;
      logic                  best_valid;
   } rsp_type;

endpackage

>>> rtl/hough_vote_accumulator.sv
// Sequence: from the accepting edge of a vote, an angle pass and a distance pass (each 24
//    divider steps and a fix-up), then range check, table read and table write.
// One vote at a time on the shared bit-serial divider; req_ready is high only when idle.
// Reset: synchronous, active high. Afterwards a clearing pass over all THETA_BINS*R_BINS
//    entries (4096 at the defaults) zeroes the vote table; req_ready stays low meanwhile,
//    configuration writes are taken as ever.
module hough_vote_accumulator #(
   parameter int THETA_BINS = 64,
   parameter int R_BINS     = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // vote channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  hva_pkg::req_type                     req_data,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output hva_pkg::rsp_type                     rsp_data,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [hva_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [hva_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [hva_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready
);

   localparam int VB         = hva_pkg::VALUE_BITS;
   localparam int CB         = hva_pkg::COUNT_BITS;
   localparam int RB         = hva_pkg::RES_BITS;
   localparam int FB         = hva_pkg::FIRST_BITS;
   localparam int IB         = hva_pkg::INDEX_BITS;
   localparam int DB         = hva_pkg::CSR_DATA_BITS;
   // signed bin index: quotient magnitude plus sign plus headroom for the offset
   localparam int QW         = VB + 2;
   localparam int TABLE_SIZE = THETA_BINS * R_BINS;
   localparam int AW         = $clog2(TABLE_SIZE);
   localparam int TW         = $clog2(THETA_BINS);
   localparam int RW         = $clog2(R_BINS);
   localparam int SW         = $clog2(VB);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_FIX,
      ST_CHECK,
      ST_READ,
      ST_FINISH
   } state_type;

   // ---------------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------------
   state_type              state_ff,       state_in;
   logic [AW-1:0]          clr_addr_ff,    clr_addr_in;

   logic [RB-1:0]          theta_res_ff,   theta_res_in;
   logic [RB-1:0]          r_res_ff,       r_res_in;
   logic signed [FB-1:0]   theta_first_ff, theta_first_in;
   logic signed [FB-1:0]   r_first_ff,     r_first_in;

   logic signed [VB-1:0]   r_hold_ff,      r_hold_in;   // distance waits for its turn
   logic                   sel_r_ff,       sel_r_in;    // 0: angle pass, 1: distance pass
   logic [VB-1:0]          quo_ff,         quo_in;      // dividend in, quotient out
   logic [RB-1:0]          rem_ff,         rem_in;
   logic [RB-1:0]          divisor_ff,     divisor_in;
   logic                   neg_ff,         neg_in;
   logic [SW-1:0]          step_ff,        step_in;

   logic signed [QW-1:0]   ti_ff,          ti_in;
   logic signed [QW-1:0]   ri_ff,          ri_in;
   logic                   drop_ff,        drop_in;
   logic [AW-1:0]          addr_ff,        addr_in;

   logic [CB-1:0]          top_count_ff,   top_count_in;
   logic [TW-1:0]          top_t_ff,       top_t_in;
   logic [RW-1:0]          top_r_ff,       top_r_in;
   logic                   top_seen_ff,    top_seen_in;

   logic                   rsp_valid_ff,   rsp_valid_in;
   hva_pkg::rsp_type       rsp_data_ff,    rsp_data_in;

   // vote table
   logic [CB-1:0]          table_mem [TABLE_SIZE];
   logic [CB-1:0]          rdata_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [CB-1:0]          mem_wdata;

   // ---------------------------------------------------------------------------------
   // configuration port: writes land on psel & penable & pwrite, no wait states
   // ---------------------------------------------------------------------------------
   logic csr_write;
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      theta_res_in   = theta_res_ff;
      r_res_in       = r_res_ff;
      theta_first_in = theta_first_ff;
      r_first_in     = r_first_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            hva_pkg::REG_THETA_RES:   theta_res_in   = pwdata[RB-1:0];
            hva_pkg::REG_R_RES:       r_res_in       = pwdata[RB-1:0];
            hva_pkg::REG_THETA_FIRST: theta_first_in = $signed(pwdata[FB-1:0]);
            hva_pkg::REG_R_FIRST:     r_first_in     = $signed(pwdata[FB-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         hva_pkg::REG_THETA_RES:   prdata = DB'(theta_res_ff);
         hva_pkg::REG_R_RES:       prdata = DB'(r_res_ff);
         hva_pkg::REG_THETA_FIRST: prdata = DB'(theta_first_ff);   // sign-extended
         hva_pkg::REG_R_FIRST:     prdata = DB'(r_first_ff);
         default:                  prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // shared divider: one restoring step per cycle on magnitudes
   // ---------------------------------------------------------------------------------
   logic [RB:0]   trial;       // shifted remainder
   logic [RB+1:0] diff;        // trial minus divisor, MSB is the borrow
   logic          fits;
   assign trial = {rem_ff, quo_ff[VB-1]};
   assign diff  = {1'b0, trial} - {2'b00, divisor_ff};
   assign fits  = !diff[RB+1];

   // floor fix-up: negative dividend with non-zero remainder rounds one further down
   logic signed [QW-1:0] q_ext;
   logic signed [QW-1:0] q_floor;
   logic signed [QW-1:0] bin_idx;
   assign q_ext   = $signed({2'b00, quo_ff});
   assign q_floor = !neg_ff ? q_ext : ((rem_ff != '0) ? ~q_ext : -q_ext);
   assign bin_idx = q_floor - QW'(sel_r_ff ? r_first_ff : theta_first_ff);

   // zero resolution counts as one
   logic [RB-1:0] theta_div;
   logic [RB-1:0] r_div;
   assign theta_div = (theta_res_ff == '0) ? RB'(1) : theta_res_ff;
   assign r_div     = (r_res_ff == '0)     ? RB'(1) : r_res_ff;

   // ---------------------------------------------------------------------------------
   // range check and table address (row-major: distance row, angle column)
   // ---------------------------------------------------------------------------------
   logic          in_range;
   logic [AW-1:0] row_base;
   assign in_range = !ti_ff[QW-1] && (ti_ff < QW'(THETA_BINS)) &&
                     !ri_ff[QW-1] && (ri_ff < QW'(R_BINS));
   assign row_base = AW'(32'(ri_ff[RW-1:0]) * THETA_BINS);

   // saturating increment of the counter just read
   logic [CB-1:0] count_inc;
   logic          new_best;
   logic          commit;
   assign count_inc = (rdata_ff == '1) ? rdata_ff : rdata_ff + CB'(1);
   assign new_best  = !top_seen_ff || (count_inc > top_count_ff);
   assign commit    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // ---------------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      r_hold_in    = r_hold_ff;
      sel_r_in     = sel_r_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      ti_in        = ti_ff;
      ri_in        = ri_ff;
      drop_in      = drop_ff;
      addr_in      = addr_ff;
      top_count_in = top_count_ff;
      top_t_in     = top_t_ff;
      top_r_in     = top_r_ff;
      top_seen_in  = top_seen_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(TABLE_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               // angle pass first; distance kept for the second pass
               r_hold_in  = req_data.r_value;
               sel_r_in   = 1'b0;
               neg_in     = req_data.theta_value[VB-1];
               quo_in     = req_data.theta_value[VB-1] ? VB'(-req_data.theta_value)
                                                       : VB'(req_data.theta_value);
               rem_in     = '0;
               divisor_in = theta_div;
               step_in    = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in  = {quo_ff[VB-2:0], fits};
            rem_in  = fits ? diff[RB-1:0] : trial[RB-1:0];
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(VB - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (!sel_r_ff) begin
               ti_in      = bin_idx;
               sel_r_in   = 1'b1;
               neg_in     = r_hold_ff[VB-1];
               quo_in     = r_hold_ff[VB-1] ? VB'(-r_hold_ff) : VB'(r_hold_ff);
               rem_in     = '0;
               divisor_in = r_div;
               step_in    = '0;
               state_in   = ST_DIV;
            end else begin
               ri_in    = bin_idx;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            drop_in  = !in_range;
            addr_in  = row_base + AW'(ti_ff[TW-1:0]);
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_FINISH;   // table data registered at this edge
         end
         ST_FINISH: begin
            if (commit) begin
               if (!drop_ff && new_best) begin
                  top_count_in = count_inc;
                  top_t_in     = ti_ff[TW-1:0];
                  top_r_in     = ri_ff[RW-1:0];
                  top_seen_in  = 1'b1;
               end
               // best-bin indexes widened or trimmed to the field width
               rsp_data_in.bin_count        = drop_ff ? '0 : count_inc;
               rsp_data_in.out_of_range     = drop_ff;
               rsp_data_in.best_count       = top_count_in;
               rsp_data_in.best_theta_index = IB'(top_t_in);
               rsp_data_in.best_r_index     = IB'(top_r_in);
               rsp_data_in.best_valid       = top_seen_in;
               rsp_valid_in                 = 1'b1;
               state_in                     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         theta_res_ff   <= hva_pkg::RES_RESET;
         r_res_ff       <= hva_pkg::RES_RESET;
         theta_first_ff <= $signed(hva_pkg::FIRST_RESET);
         r_first_ff     <= $signed(hva_pkg::FIRST_RESET);
         top_count_ff   <= '0;
         top_t_ff       <= '0;
         top_r_ff       <= '0;
         top_seen_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         theta_res_ff   <= theta_res_in;
         r_res_ff       <= r_res_in;
         theta_first_ff <= theta_first_in;
         r_first_ff     <= r_first_in;
         top_count_ff   <= top_count_in;
         top_t_ff       <= top_t_in;
         top_r_ff       <= top_r_in;
         top_seen_ff    <= top_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      r_hold_ff   <= r_hold_in;
      sel_r_ff    <= sel_r_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      ti_ff       <= ti_in;
      ri_ff       <= ri_in;
      drop_ff     <= drop_in;
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------------------------
   // vote table: one write port (clear or update), one registered read port
   // ---------------------------------------------------------------------------------
   assign mem_we    = (state_ff == ST_CLEAR) || (commit && !drop_ff);
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : addr_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : count_inc;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= table_mem[addr_ff];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/hva_checker.sv
module hva_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input hva_pkg::rsp_type                  rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // dropped vote reports a zero count
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |-> rsp_data.bin_count == '0)
      else $error("dropped vote with non-zero count");

   // a counted vote never beats the reported best
   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_of_range |->
         rsp_data.best_valid && (rsp_data.best_count >= rsp_data.bin_count))
      else $error("best count below counted bin");

   // busy after each accepted transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready straight after an accepted vote");

   // table clearing runs right after reset
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("ready during table clear");

endmodule

bind hough_vote_accumulator hva_checker u_hva_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> dv/hough_vote_accumulator_tb.sv
module hough_vote_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Table geometry used for this build of the block
   localparam int THETA_BINS = 64;
   localparam int R_BINS     = 64;

   localparam longint VALUE_MIN = -(longint'(1) << (hva_pkg::VALUE_BITS - 1));
   localparam longint VALUE_MAX = (longint'(1) << (hva_pkg::VALUE_BITS - 1)) - 1;
   localparam logic [hva_pkg::RES_BITS-1:0]   RES_MAX   = '1;
   localparam logic [hva_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

   // Votes per random phase; eight phases plus the directed votes give about 1550
   localparam int PHASE_VOTES  = 192;
   localparam int RANDOM_PHASES = 8;
   // Margin for the final drain, longer than the result latency
   localparam int DRAIN_CYCLES = 60;
   // Generous ceiling covering the clearing pass and ~1600 votes
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int MAX_REPORTS  = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_ready;
   hva_pkg::req_type req_data  = '0;

   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   hva_pkg::rsp_type rsp_data;

   logic                              psel    = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite  = 1'b0;
   logic [hva_pkg::CSR_ADDR_BITS-1:0] paddr   = '0;
   logic [hva_pkg::CSR_DATA_BITS-1:0] pwdata  = '0;
   logic [hva_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                              pready;

   hough_vote_accumulator #(
      .THETA_BINS (THETA_BINS),
      .R_BINS     (R_BINS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // -------------------------------------------------------------------------
   // Local copy of the accumulator: register settings, vote table and the
   // running best bin. Updated at the edge on which a vote transaction is
   // accepted, so the expected results queue up in acceptance order.
   // -------------------------------------------------------------------------
   logic        [hva_pkg::RES_BITS-1:0]   theta_res_cfg   = hva_pkg::RES_RESET;
   logic        [hva_pkg::RES_BITS-1:0]   r_res_cfg       = hva_pkg::RES_RESET;
   logic signed [hva_pkg::FIRST_BITS-1:0] theta_first_cfg = hva_pkg::FIRST_RESET;
   logic signed [hva_pkg::FIRST_BITS-1:0] r_first_cfg     = hva_pkg::FIRST_RESET;

   logic [hva_pkg::COUNT_BITS-1:0] vote_tally [THETA_BINS*R_BINS] = '{default: '0};
   logic [hva_pkg::COUNT_BITS-1:0] top_count     = '0;
   logic [hva_pkg::INDEX_BITS-1:0] top_theta_idx = '0;
   logic [hva_pkg::INDEX_BITS-1:0] top_r_idx     = '0;
   logic                           top_seen      = 1'b0;

   // Results still owed by the block, oldest first
   hva_pkg::rsp_type tally_q [$];

   int mismatches   = 0;
   int send_idle_pct = 0;  // chance per cycle that the vote source holds off
   int rsp_stall_pct = 0;  // chance per cycle that the result sink stalls

   // A handful of bins that most random votes pile into, so counts climb and
   // the best bin changes hands repeatedly
   int hot_theta [4];
   int hot_r     [4];

   // Division by the bin width, rounded toward minus infinity. A zero width
   // behaves as a width of one.
   function automatic longint floor_bin(input longint value,
                                        input logic [hva_pkg::RES_BITS-1:0] res);
      longint d;
      longint q;
      d = (res == '0) ? 1 : longint'(res);
      q = value / d;
      if ((value % d) != 0 && value < 0)
         q = q - 1;
      return q;
   endfunction

   function automatic hva_pkg::rsp_type tally_vote(input hva_pkg::req_type v);
      longint           ti;
      longint           ri;
      int unsigned      slot;
      hva_pkg::rsp_type r;
      ti = floor_bin($signed(v.theta_value), theta_res_cfg) - longint'(theta_first_cfg);
      ri = floor_bin($signed(v.r_value), r_res_cfg) - longint'(r_first_cfg);
      r = '0;
      r.out_of_range = 1'b1;
      if (ti >= 0 && ti < THETA_BINS && ri >= 0 && ri < R_BINS) begin
         slot = int'(ri) * THETA_BINS + int'(ti);
         // counters stick at full scale
         if (vote_tally[slot] != COUNT_MAX)
            vote_tally[slot] = vote_tally[slot] + hva_pkg::COUNT_BITS'(1);
         r.bin_count    = vote_tally[slot];
         r.out_of_range = 1'b0;
         // only a strictly higher count takes over; a tie leaves the old best
         if (!top_seen || vote_tally[slot] > top_count) begin
            top_count     = vote_tally[slot];
            top_theta_idx = hva_pkg::INDEX_BITS'(ti);
            top_r_idx     = hva_pkg::INDEX_BITS'(ri);
            top_seen      = 1'b1;
         end
      end
      r.best_count       = top_count;
      r.best_theta_index = top_theta_idx;
      r.best_r_index     = top_r_idx;
      r.best_valid       = top_seen;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------
   function automatic void compare_field(input string field, input longint want,
                                         input longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
      end
   endfunction

   function automatic void match_result(input hva_pkg::rsp_type got);
      hva_pkg::rsp_type want;
      if (tally_q.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: result transaction with nothing expected, got %h", $realtime, got);
         return;
      end
      want = tally_q.pop_front();
      compare_field("bin_count",        want.bin_count,        got.bin_count);
      compare_field("out_of_range",     want.out_of_range,     got.out_of_range);
      compare_field("best_count",       want.best_count,       got.best_count);
      compare_field("best_theta_index", want.best_theta_index, got.best_theta_index);
      compare_field("best_r_index",     want.best_r_index,     got.best_r_index);
      compare_field("best_valid",       want.best_valid,       got.best_valid);
   endfunction

   // Result sink: checks on the accepting edge, then picks the next ready level.
   // Reads see pre-edge values, so there is no race with the block's flops.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         match_result(rsp_data);
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // Setup phase, access phase, register taken on the edge where pready is seen
   task automatic csr_write(input logic [1:0] reg_index,
                            input logic [hva_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (reg_index)
         hva_pkg::REG_THETA_RES:   theta_res_cfg   = value[hva_pkg::RES_BITS-1:0];
         hva_pkg::REG_R_RES:       r_res_cfg       = value[hva_pkg::RES_BITS-1:0];
         hva_pkg::REG_THETA_FIRST: theta_first_cfg = value[hva_pkg::FIRST_BITS-1:0];
         hva_pkg::REG_R_FIRST:     r_first_cfg     = value[hva_pkg::FIRST_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(input logic [hva_pkg::RES_BITS-1:0] th_res,
                                 input logic [hva_pkg::RES_BITS-1:0] r_res,
                                 input logic signed [hva_pkg::FIRST_BITS-1:0] th_first,
                                 input logic signed [hva_pkg::FIRST_BITS-1:0] r_first);
      csr_write(hva_pkg::REG_THETA_RES,   hva_pkg::CSR_DATA_BITS'(th_res));
      csr_write(hva_pkg::REG_R_RES,       hva_pkg::CSR_DATA_BITS'(r_res));
      csr_write(hva_pkg::REG_THETA_FIRST, hva_pkg::CSR_DATA_BITS'(th_first));
      csr_write(hva_pkg::REG_R_FIRST,     hva_pkg::CSR_DATA_BITS'(r_first));
   endtask

   // Offers one vote and returns on the edge that accepts it. valid is left
   // high so a following vote can go out back to back; await_results drops it.
   task automatic send_vote(input hva_pkg::req_type v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= v;
      do @(posedge clock); while (!req_ready);
      tally_q.push_back(tally_vote(v));
   endtask

   // Source goes quiet until every owed result has been through the sink
   task automatic await_results();
      req_valid <= 1'b0;
      while (tally_q.size() != 0)
         @(posedge clock);
   endtask

   function automatic hva_pkg::req_type vote_at(input longint theta, input longint r);
      hva_pkg::req_type v;
      v.theta_value = hva_pkg::VALUE_BITS'(theta);
      v.r_value     = hva_pkg::VALUE_BITS'(r);
      return v;
   endfunction

   // -------------------------------------------------------------------------
   // Random vote generation
   // -------------------------------------------------------------------------
   function automatic logic [hva_pkg::RES_BITS-1:0] pick_resolution();
      case ($urandom_range(5))
         0:       return hva_pkg::RES_BITS'(1);
         1:       return hva_pkg::RES_BITS'(4096);
         2:       return RES_MAX;
         3:       return hva_pkg::RES_BITS'($urandom_range(255, 2));
         4:       return hva_pkg::RES_BITS'($urandom_range(65535, 256));
         default: return hva_pkg::RES_BITS'($urandom);
      endcase
   endfunction

   // Mostly a first bin that keeps part of the table reachable by 24-bit
   // values; now and then anything at all
   function automatic logic signed [hva_pkg::FIRST_BITS-1:0] pick_first_bin(
         input logic [hva_pkg::RES_BITS-1:0] res);
      longint lo;
      longint hi;
      longint first;
      if ($urandom_range(7) == 0)
         return hva_pkg::FIRST_BITS'($urandom);
      lo = floor_bin(VALUE_MIN, res) - 63;
      hi = floor_bin(VALUE_MAX, res);
      first = lo + longint'($urandom_range(32'(hi - lo)));
      if (first < VALUE_MIN)
         first = VALUE_MIN;
      return hva_pkg::FIRST_BITS'(first);
   endfunction

   // A value somewhere inside the bin that lands on table index idx; if that
   // bin cannot be expressed in 24 bits, any value will do
   function automatic logic signed [hva_pkg::VALUE_BITS-1:0] aim_value(input longint idx,
         input logic signed [hva_pkg::FIRST_BITS-1:0] first,
         input logic [hva_pkg::RES_BITS-1:0] res);
      longint d;
      longint v;
      d = (res == '0) ? 1 : longint'(res);
      v = (idx + longint'(first)) * d + longint'($urandom_range(32'(d - 1)));
      if (v < VALUE_MIN || v > VALUE_MAX)
         v = longint'($signed(hva_pkg::VALUE_BITS'($urandom)));
      return hva_pkg::VALUE_BITS'(v);
   endfunction

   function automatic hva_pkg::req_type random_vote();
      hva_pkg::req_type v;
      int unsigned      sel;
      int unsigned      k;
      longint           ti;
      longint           ri;
      sel = $urandom_range(99);
      k   = $urandom_range(3);
      ti  = hot_theta[k];
      ri  = hot_r[k];
      if (sel >= 55 && sel < 85) begin
         // anywhere in the table
         ti = $urandom_range(THETA_BINS - 1);
         ri = $urandom_range(R_BINS - 1);
      end else if (sel >= 85) begin
         // just off one side of the table on one axis
         ti = $urandom_range(THETA_BINS - 1);
         ri = $urandom_range(R_BINS - 1);
         if ($urandom_range(1))
            ti = longint'($urandom_range(1)) * (THETA_BINS + 1) - 1;
         else
            ri = longint'($urandom_range(1)) * (R_BINS + 1) - 1;
      end
      v.theta_value = aim_value(ti, theta_first_cfg, theta_res_cfg);
      v.r_value     = aim_value(ri, r_first_cfg, r_res_cfg);
      // raw noise: every bit pattern of both fields
      if (sel >= 93) begin
         v.theta_value = hva_pkg::VALUE_BITS'($urandom);
         v.r_value     = hva_pkg::VALUE_BITS'($urandom);
      end
      return v;
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // Reset settings: width 4096 units, first bin -32, so values in
   // [-131072, 131071] fill the table exactly
   task automatic test_default_binning();
      send_vote(vote_at(-131073, 0));              // dropped before any count: best invalid
      send_vote(vote_at(0, 0));                    // first count claims the best slot
      send_vote(vote_at(0, 0));
      send_vote(vote_at(-131072, -131072));        // bottom corner of the table
      send_vote(vote_at(131071, 131071));          // top corner
      send_vote(vote_at(0, 131072));               // one past the last row
      send_vote(vote_at(-131072, -131073));        // one before the first row
      send_vote(vote_at(131072, 0));               // one past the last column
      send_vote(vote_at(VALUE_MIN, VALUE_MIN));
      send_vote(vote_at(VALUE_MAX, VALUE_MAX));
      send_vote(vote_at(-1, -1));                  // negative values floor downwards
      send_vote(vote_at(-4096, 4095));
      send_vote(vote_at(-131072, -131072));        // ties the best count: no takeover
      send_vote(vote_at(-131072, -131072));        // now strictly higher
      await_results();
   endtask

   // A zero width divides by one
   task automatic test_zero_resolution();
      write_settings('0, '0, hva_pkg::FIRST_RESET, hva_pkg::FIRST_RESET);
      send_vote(vote_at(-32, 31));
      send_vote(vote_at(31, -32));
      send_vote(vote_at(-33, 0));
      await_results();
   endtask

   task automatic test_register_extremes();
      // widest bins: only a few bins exist across the whole value range
      write_settings(RES_MAX, RES_MAX, hva_pkg::FIRST_BITS'(-2), hva_pkg::FIRST_BITS'(-2));
      send_vote(vote_at(VALUE_MIN, VALUE_MAX));
      send_vote(vote_at(-1, -1));
      await_results();
      // finest bins pinned to the bottom of the value range
      write_settings(hva_pkg::RES_BITS'(1), hva_pkg::RES_BITS'(1),
                     hva_pkg::FIRST_BITS'(VALUE_MIN), hva_pkg::FIRST_BITS'(VALUE_MIN));
      send_vote(vote_at(VALUE_MIN, VALUE_MIN + 63));
      send_vote(vote_at(VALUE_MIN + 64, VALUE_MIN));
      await_results();
      // and to the top
      write_settings(hva_pkg::RES_BITS'(1), hva_pkg::RES_BITS'(1),
                     hva_pkg::FIRST_BITS'(VALUE_MAX), hva_pkg::FIRST_BITS'(VALUE_MAX));
      send_vote(vote_at(VALUE_MAX, VALUE_MAX));
      send_vote(vote_at(VALUE_MAX - 1, VALUE_MAX));
      await_results();
   endtask

   // Phases cycle through the idling modes; each gets fresh register
   // settings and a fresh set of hot bins. The table carries over.
   task automatic test_random_votes();
      logic [hva_pkg::RES_BITS-1:0] th_res;
      logic [hva_pkg::RES_BITS-1:0] r_res;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         await_results();
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin send_idle_pct = 34; rsp_stall_pct = 34; end
         endcase
         th_res = pick_resolution();
         r_res  = pick_resolution();
         write_settings(th_res, r_res, pick_first_bin(th_res), pick_first_bin(r_res));
         foreach (hot_theta[k]) begin
            hot_theta[k] = $urandom_range(THETA_BINS - 1);
            hot_r[k]     = $urandom_range(R_BINS - 1);
         end
         for (int n = 0; n < PHASE_VOTES; n++) begin
            send_vote(random_vote());
            // occasionally let the block run completely dry mid-phase
            if ($urandom_range(59) == 0)
               await_results();
         end
      end
      await_results();
   endtask

   // -------------------------------------------------------------------------
   // Clock, watchdog and sequencing
   // -------------------------------------------------------------------------
   initial begin
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // votes simply wait out the table clearing pass behind req_ready
      test_default_binning();
      test_zero_resolution();
      test_register_extremes();
      test_random_votes();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // anything arriving now is a stray transaction and gets flagged
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && tally_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
rtl/hva_pkg.sv
rtl/hough_vote_accumulator.sv
rtl/hva_checker.sv
dv/hough_vote_accumulator_tb.sv
